// ----- hdl/stepper_trapezoid_ramp_assert.svh -----
// Assertion macros for the stepper ramp generator.
// Included by the ramp top level, which checks its own logic; needs nothing else.
`ifndef STEPPER_TRAPEZOID_RAMP_ASSERT_SVH
`define STEPPER_TRAPEZOID_RAMP_ASSERT_SVH
`ifndef ASSERT_OFF
// property checked on every edge outside reset
`define STPR_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// cause in one cycle, effect in the next
`define STPR_ASSERT_NEXT(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) pre |=> post) else $error(msg);
`else
`define STPR_ASSERT(lbl, ck, rn, prop, msg)
`define STPR_ASSERT_NEXT(lbl, ck, rn, pre, post, msg)
`endif
`endif

// ----- hdl/stpr_pkg.sv -----
// Shared constants for the stepper ramp generator: unit sizes, config
// indexes and reset values, modes, result codes, ramp limits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stpr_pkg;

  // serial divider and root unit sizes
  localparam int DIV_DW = 64;
  localparam int DIV_VW = 34;
  localparam int SQ_W   = 48;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_NUM  = 2'd0;
  localparam logic [1:0] CFG_FD_SCALE = 2'd1;
  localparam logic [1:0] CFG_SQ_NUM   = 2'd2;
  localparam logic [1:0] CFG_RD_FACT  = 2'd3;

  // configuration reset values
  localparam logic [31:0] MIN_NUM_RST  = 32'd3141592;
  localparam logic [31:0] FD_SCALE_RST = 32'd1730560;
  localparam logic [31:0] SQ_NUM_RST   = 32'd628318530;
  localparam logic [15:0] RD_FACT_RST  = 16'd628;

  // ramp modes
  localparam logic [2:0] MODE_STOP   = 3'd0;
  localparam logic [2:0] MODE_ACCEL  = 3'd1;
  localparam logic [2:0] MODE_RUN    = 3'd2;
  localparam logic [2:0] MODE_DECEL  = 3'd3;
  localparam logic [2:0] MODE_FINISH = 3'd4;

  // start results
  localparam logic [1:0] RES_TICK  = 2'd0;
  localparam logic [1:0] RES_START = 2'd1;
  localparam logic [1:0] RES_SHORT = 2'd2;
  localparam logic [1:0] RES_ZERO  = 2'd3;

  // fixed ramp constants
  localparam int          STEPS_PER_REV = 12800;
  localparam logic [31:0] OVER_LIM      = 32'(STEPS_PER_REV + 200);
  localparam logic [15:0] CNT_WRAP      = 16'd50000;
  localparam logic [33:0] FD_DIV        = 34'd6553600;
  localparam logic [33:0] RD_DIV        = 34'd100;

endpackage
`default_nettype wire

// ----- hdl/stepper_trapezoid_ramp.sv -----
// Trapezoidal stepper speed ramp generator, top level.
// Uses stpr_pkg, stpr_div, stpr_isqrt and the assertion macro header.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: steps,accel,decel,speed,counter
//  out_    | out | out_tvalid/out_tready| tdata: timing,flags,position; tuser
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item at a time. A run or idle tick goes straight to the result; an accel
// or decel tick adds a ramp count step, a decel tick with no update ends there,
// and the delay recurrence, when it runs, takes one pass of the 64-step serial
// divider. A start that computes a ramp takes six or seven divider passes, the
// seventh when the decel point comes from top speed, plus one pass of the root
// unit. Rejected starts go straight to the result.
// Reset is synchronous; all ramp state clears to stop. The result sits in an
// output register, so a stalled result holds the sequencer only at its end.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_trapezoid_ramp_assert.svh"
module stepper_trapezoid_ramp #(
  parameter int STEPS_PER_REV = stpr_pkg::STEPS_PER_REV
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [16:0] move_steps, [32:17] accel, [48:33] decel, [64:49] speed,
  // [80:65] counter_value
  input  wire logic [87:0]  in_tdata,
  // [0] operation
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] period, [62:32] compare_value, [65:63] ramp_state, [66] running,
  // [67] move_done, [68] overshoot, [100:69] position
  output logic [103:0]      out_tdata,
  // [1:0] start_result
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_DEC = 5'd1,  S_MIND = 5'd2,
                         S_Q1   = 5'd3,  S_SQ  = 5'd4,  S_MP   = 5'd5,
                         S_FD   = 5'd6,  S_M2  = 5'd7,  S_DF   = 5'd8,
                         S_M3   = 5'd9,  S_MX  = 5'd10, S_M4   = 5'd11,
                         S_AL   = 5'd12, S_M5  = 5'd13, S_DV   = 5'd14,
                         S_FIN  = 5'd15, S_TK2 = 5'd16, S_REC  = 5'd17,
                         S_OUT  = 5'd18;

  // overshoot limit: one revolution plus margin
  localparam logic [31:0] OVER_LIM = 32'(STEPS_PER_REV + 200);

  // configuration
  logic [31:0] min_num_r, fd_scale_r, sq_num_r;
  logic [15:0] rd_fact_r;

  // ramp state
  logic        ccw_r, running_r;
  logic [16:0] target_r;
  logic [31:0] min_delay_r, sd_r, doff_r, dss_r, rc_r, rem_r, last_r, ts_r, pos_r;
  logic [2:0]  mode_r;

  // sequencer and item
  logic [4:0]  state_r;
  logic        lch_r, op_r;
  logic [16:0] raw_r, mag_r;
  logic [15:0] accel_r, decel_r, speed_r, cnt_r;
  logic [31:0] period_r, q1_r, fd_r, divf_r, maxs_r, dv_r;
  logic [1:0]  res_r;
  logic        done_r, over_r;
  logic [33:0] nmag_r, dmag_r;
  logic        nneg_r, dneg_r;

  // output register
  logic         out_valid_r;
  logic [103:0] out_data_r;
  logic [1:0]   out_user_r;

  // shared multiplier
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p_r;

  // serial units
  logic        div_start, div_busy, div_done, div_wait;
  logic [63:0] div_dvd, div_quot;
  logic [33:0] div_dvs, div_rem;
  logic        sq_start, sq_busy, sq_done;
  logic [23:0] sq_root;

  // combinational helpers
  logic [16:0] mag_c;
  logic [15:0] m_c;
  logic [34:0] n_c, d_c, n_mag, d_mag, q_s, r_s;
  logic [31:0] nd_c, doff_c, acl_c;
  logic        mode_moving;

  function automatic logic [15:0] meas(input logic [15:0] c, input logic ccw,
                                       input logic [31:0] rc);
    logic [15:0] s;
    s = ccw ? stpr_pkg::CNT_WRAP - c : c;
    if (s > stpr_pkg::CNT_WRAP) s = rc[15:0];
    return s;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // operand selection for multiplier, divider and root unit
  always_comb begin
    mul_a = 32'd0;
    mul_b = 24'd0;
    unique case (state_r)
      S_MP:    begin mul_a = fd_scale_r;        mul_b = sq_root;            end
      S_M2:    begin mul_a = {16'd0, rd_fact_r}; mul_b = {8'd0, accel_r};    end
      S_M3:    begin mul_a = {16'd0, speed_r};   mul_b = {8'd0, speed_r};    end
      S_M4:    begin mul_a = {16'd0, decel_r};   mul_b = {7'd0, mag_r};      end
      S_M5:    begin mul_a = maxs_r;             mul_b = {8'd0, accel_r};    end
      default: begin mul_a = 32'd0;              mul_b = 24'd0;              end
    endcase
    div_dvd = {8'd0, mul_p_r};
    div_dvs = 34'd1;
    unique case (state_r)
      S_MIND:  begin div_dvd = {32'd0, min_num_r}; div_dvs = {18'd0, speed_r}; end
      S_Q1:    begin div_dvd = {32'd0, sq_num_r};  div_dvs = {18'd0, accel_r}; end
      S_FD:    div_dvs = stpr_pkg::FD_DIV;
      S_DF:    div_dvs = stpr_pkg::RD_DIV;
      S_MX:    div_dvs = {2'd0, divf_r};
      S_AL:    div_dvs = {17'd0, 1'b0, accel_r} + {17'd0, 1'b0, decel_r};
      S_DV:    div_dvs = {18'd0, decel_r};
      S_REC:   begin div_dvd = {30'd0, nmag_r}; div_dvs = dmag_r; end
      default: begin div_dvd = {8'd0, mul_p_r}; div_dvs = 34'd1; end
    endcase
    div_wait  = (state_r == S_MIND || state_r == S_Q1 || state_r == S_FD ||
                 state_r == S_DF || state_r == S_MX || state_r == S_AL ||
                 state_r == S_DV || state_r == S_REC);
    div_start = lch_r && div_wait;
    sq_start  = lch_r && (state_r == S_SQ);
  end

  // magnitude, measured count, recurrence operands and result
  always_comb begin
    mag_c  = raw_r[16] ? 17'd0 - raw_r : raw_r;
    m_c    = meas(cnt_r, ccw_r, rc_r);
    n_c    = {2'b00, sd_r, 1'b0} + {{3{rem_r[31]}}, rem_r};
    d_c    = {rc_r[31], rc_r, 2'b01};
    n_mag  = n_c[34] ? -n_c : n_c;
    d_mag  = d_c[34] ? -d_c : d_c;
    q_s    = (nneg_r ^ dneg_r) ? -{1'b0, div_quot[33:0]} : {1'b0, div_quot[33:0]};
    r_s    = nneg_r ? -{1'b0, div_rem} : {1'b0, div_rem};
    nd_c   = sd_r - q_s[31:0];
    acl_c  = (div_quot[31:0] == 32'd0) ? 32'd1 : div_quot[31:0];
    doff_c = (dv_r == 32'd0) ? 32'hFFFF_FFFF : dv_r;
    mode_moving = (mode_r == stpr_pkg::MODE_ACCEL) || (mode_r == stpr_pkg::MODE_RUN) ||
                  (mode_r == stpr_pkg::MODE_DECEL);
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_num_r  <= stpr_pkg::MIN_NUM_RST;
      fd_scale_r <= stpr_pkg::FD_SCALE_RST;
      sq_num_r   <= stpr_pkg::SQ_NUM_RST;
      rd_fact_r  <= stpr_pkg::RD_FACT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stpr_pkg::CFG_MIN_NUM:  min_num_r  <= cfg_data;
        stpr_pkg::CFG_FD_SCALE: fd_scale_r <= cfg_data;
        stpr_pkg::CFG_SQ_NUM:   sq_num_r   <= cfg_data;
        stpr_pkg::CFG_RD_FACT:  rd_fact_r  <= cfg_data[15:0];
        default:                rd_fact_r  <= rd_fact_r;
      endcase
    end
  end

  // item latch (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_tuser;
      raw_r   <= in_tdata[16:0];
      accel_r <= in_tdata[32:17];
      decel_r <= in_tdata[48:33];
      speed_r <= in_tdata[64:49];
      cnt_r   <= in_tdata[80:65];
    end
  end

  // sequencer and ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  lch_r <= 1'b0;
      ccw_r <= 1'b0;  running_r <= 1'b0;  target_r <= '0;
      min_delay_r <= '0;  sd_r <= '0;  doff_r <= '0;  dss_r <= '0;
      rc_r <= '0;  rem_r <= '0;  last_r <= '0;  ts_r <= '0;  pos_r <= '0;
      mode_r <= stpr_pkg::MODE_STOP;
      res_r <= stpr_pkg::RES_TICK;  done_r <= 1'b0;  over_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lch_r <= 1'b0;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) state_r <= S_DEC;
        S_DEC: begin
          done_r <= 1'b0;
          over_r <= 1'b0;
          res_r  <= stpr_pkg::RES_TICK;
          period_r <= sd_r;
          if (!op_r) begin
            mag_r   <= mag_c;
            ccw_r   <= raw_r[16];
            state_r <= S_OUT;
            if (mag_c < 17'd3) begin
              res_r <= stpr_pkg::RES_SHORT;
            end else begin
              target_r <= mag_c;
              if (mag_c < 17'd4) begin
                res_r <= stpr_pkg::RES_SHORT;
              end else if (accel_r == 16'd0 || decel_r == 16'd0 || speed_r == 16'd0) begin
                res_r <= stpr_pkg::RES_ZERO;
              end else begin
                lch_r   <= 1'b1;
                state_r <= S_MIND;
              end
            end
          end else if (running_r && (mode_r == stpr_pkg::MODE_ACCEL ||
                                     mode_r == stpr_pkg::MODE_DECEL)) begin
            pos_r   <= ccw_r ? pos_r - 32'd1 : pos_r + 32'd1;
            ts_r    <= ts_r + 32'd1;
            rc_r    <= rc_r + 32'd1;
            state_r <= S_TK2;
          end else if (running_r && mode_r == stpr_pkg::MODE_RUN) begin
            pos_r <= ccw_r ? pos_r - 32'd1 : pos_r + 32'd1;
            ts_r  <= ts_r + 32'd1;
            if ({16'd0, m_c} >= dss_r) begin
              rc_r   <= doff_r;
              sd_r   <= last_r;
              mode_r <= stpr_pkg::MODE_DECEL;
            end else begin
              sd_r <= min_delay_r;
            end
            state_r <= S_OUT;
          end else begin
            state_r <= S_OUT;
          end
        end
        // start computation chain
        S_MIND: if (div_done) begin
          min_delay_r <= div_quot[31:0];
          lch_r <= 1'b1;  state_r <= S_Q1;
        end
        S_Q1: if (div_done) begin
          q1_r  <= div_quot[31:0];
          lch_r <= 1'b1;  state_r <= S_SQ;
        end
        S_SQ: if (sq_done) state_r <= S_MP;
        S_MP: begin lch_r <= 1'b1; state_r <= S_FD; end
        S_FD: if (div_done) begin
          fd_r <= (div_quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quot[31:0];
          state_r <= S_M2;
        end
        S_M2: begin lch_r <= 1'b1; state_r <= S_DF; end
        S_DF: if (div_done) begin
          divf_r  <= acl_c;
          state_r <= S_M3;
        end
        S_M3: begin lch_r <= 1'b1; state_r <= S_MX; end
        S_MX: if (div_done) begin
          maxs_r  <= acl_c;
          state_r <= S_M4;
        end
        S_M4: begin lch_r <= 1'b1; state_r <= S_AL; end
        S_AL: if (div_done) begin
          if (acl_c <= maxs_r) begin
            dv_r    <= acl_c - {15'd0, mag_r};
            state_r <= S_FIN;
          end else begin
            state_r <= S_M5;
          end
        end
        S_M5: begin lch_r <= 1'b1; state_r <= S_DV; end
        S_DV: if (div_done) begin
          dv_r    <= -div_quot[31:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          doff_r <= doff_c;
          dss_r  <= {15'd0, mag_r} + doff_c;
          if (fd_r <= min_delay_r) begin
            sd_r   <= min_delay_r;
            mode_r <= stpr_pkg::MODE_RUN;
          end else begin
            sd_r   <= fd_r;
            mode_r <= stpr_pkg::MODE_ACCEL;
          end
          rc_r      <= '0;
          running_r <= 1'b1;
          res_r     <= stpr_pkg::RES_START;
          state_r   <= S_OUT;
        end
        // tick, after the ramp count step
        S_TK2: begin
          nmag_r <= n_mag[33:0];
          dmag_r <= d_mag[33:0];
          nneg_r <= n_c[34];
          dneg_r <= d_c[34];
          if (mode_r == stpr_pkg::MODE_ACCEL) begin
            lch_r <= 1'b1;  state_r <= S_REC;
          end else if ({1'b0, m_c} > target_r) begin
            running_r <= 1'b0;
            done_r    <= 1'b1;
            if ({16'd0, m_c} > OVER_LIM) begin
              over_r <= 1'b1;
            end else begin
              ts_r   <= '0;
              rem_r  <= '0;
              mode_r <= stpr_pkg::MODE_FINISH;
            end
            state_r <= S_OUT;
          end else if (rc_r[31]) begin
            lch_r <= 1'b1;  state_r <= S_REC;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_REC: if (div_done) begin
          rem_r <= r_s[31:0];
          sd_r  <= nd_c;
          if (mode_r == stpr_pkg::MODE_ACCEL) begin
            if ({16'd0, m_c} >= dss_r) begin
              rc_r   <= doff_r;
              mode_r <= stpr_pkg::MODE_DECEL;
            end else if (nd_c <= min_delay_r) begin
              last_r <= nd_c;
              sd_r   <= min_delay_r;
              rem_r  <= '0;
              mode_r <= stpr_pkg::MODE_RUN;
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= {3'd0, pos_r, over_r, done_r, running_r, mode_r,
                     op_r ? period_r[31:1] : sd_r[31:1],
                     op_r ? period_r : sd_r};
      out_user_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  stpr_div #(.DW(stpr_pkg::DIV_DW), .VW(stpr_pkg::DIV_VW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .busy(div_busy), .done(div_done), .quot(div_quot),
    .rem(div_rem)
  );

  stpr_isqrt #(.W(stpr_pkg::SQ_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .x({q1_r, 16'd0}),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  // checks
  `STPR_ASSERT(a_run_mode, clk, rst_n, running_r |-> mode_moving, "running outside a moving mode")
  `STPR_ASSERT(a_acc_idle, clk, rst_n, in_tready |-> !div_busy && !sq_busy, "ready while busy")
  `STPR_ASSERT(a_done_wait, clk, rst_n, div_done |-> div_wait, "divider result with nobody waiting")
  `STPR_ASSERT_NEXT(a_div_go, clk, rst_n, div_start, div_busy, "divider did not start")
endmodule
`default_nettype wire

// ----- hdl/stpr_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Uses stpr_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none
module stpr_div #(
  parameter int DW = stpr_pkg::DIV_DW,
  parameter int VW = stpr_pkg::DIV_VW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [DW-1:0]      quot,
  output logic [VW-1:0]      rem
);
  localparam int CW = $clog2(DW);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] r_r, d_r, r_nxt;
  logic [VW:0]   trial, diff;
  logic          ge;

  // one shift-subtract step
  always_comb begin
    trial = {r_r, q_r[DW-1]};
    diff  = trial - {1'b0, d_r};
    ge    = trial >= {1'b0, d_r};
    r_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[DW-2:0], ge};
      r_r <= r_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

// ----- hdl/stpr_isqrt.sv -----
// Integer square root, one root bit (two radicand bits) per cycle.
// Uses stpr_pkg for the default radicand width.
`timescale 1ns / 1ps
`default_nettype none
module stpr_isqrt #(
  parameter int W = stpr_pkg::SQ_W
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   x,
  output logic                busy,
  output logic                done,
  output logic [W/2-1:0]      root
);
  localparam int RT = W / 2;
  localparam int RW = RT + 3;
  localparam int CW = $clog2(RT);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  x_r;
  logic [RT-1:0] root_r;
  logic [RW-1:0] rem_r, rem_sh, trial, rem_nxt;
  logic          ge;

  // bring in the next radicand pair and try the next root bit
  always_comb begin
    rem_sh  = {rem_r[RW-3:0], x_r[W-1:W-2]};
    trial   = {{(RW-RT-2){1'b0}}, root_r, 2'b01};
    ge      = rem_sh >= trial;
    rem_nxt = ge ? rem_sh - trial : rem_sh;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(RT - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[RT-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire
